// File: rtl/obsfb_pkg.sv
// obsfb_pkg: shared types, gain table and microcode program of the balance controller
`default_nettype none
package obsfb_pkg;

    localparam int STATE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ANGLE_W         = 16;
    localparam int ANGLE_FRAC      = 13;
    localparam int CMD_W           = 32;
    localparam int GAIN_FRAC       = 24;
    localparam int GAIN_W          = 30;
    localparam int PROG_LEN        = 24;
    localparam int PC_W            = $clog2(PROG_LEN);

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } mul_t;

    typedef enum logic [2:0] {
        SRC_AE,
        SRC_RE,
        SRC_LT,
        SRC_X,
        SRC_NA,
        SRC_NR,
        SRC_EI
    } src_t;

    typedef enum logic [3:0] {
        GN_AA,
        GN_AR,
        GN_AT,
        GN_AM,
        GN_RA,
        GN_RR,
        GN_RT,
        GN_RM,
        GN_TA,
        GN_TR,
        GN_TI
    } gain_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_ADD,
        ACC_SUB
    } acc_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_NA,
        DST_NR,
        DST_T
    } dst_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        mul_t  mul;
        src_t  src;
        gain_t gain;
        acc_t  acc;
        dst_t  dst;
        logic  integ;
        jmp_t  jmp;
        logic  last;
    } ucw_t;

    typedef struct packed {
        ucw_t word;
        logic exec;
    } ctl_t;

    function automatic logic [GAIN_W-1:0] gain_value(input gain_t g);
        logic [GAIN_W-1:0] r;
        case (g)
            GN_AA:   r = GAIN_W'(13015764);
            GN_AR:   r = GAIN_W'(46708);
            GN_AT:   r = GAIN_W'(523785);
            GN_AM:   r = GAIN_W'(18139526);
            GN_RA:   r = GAIN_W'(763690484);
            GN_RR:   r = GAIN_W'(10643466);
            GN_RT:   r = GAIN_W'(199185819);
            GN_RM:   r = GAIN_W'(787014169);
            GN_TA:   r = GAIN_W'(7857945);
            GN_TR:   r = GAIN_W'(460870);
            GN_TI:   r = GAIN_W'(251188);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic ucw_t uw(input mul_t m, input src_t s, input gain_t g,
                                input acc_t a, input dst_t d, input logic i,
                                input jmp_t j, input logic l);
        ucw_t w;
        w.mul   = m;
        w.src   = s;
        w.gain  = g;
        w.acc   = a;
        w.dst   = d;
        w.integ = i;
        w.jmp   = j;
        w.last  = l;
        return w;
    endfunction

    // two passes per product: low 24 bits, then high part plus rounded low part
    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        case (pc)
            5'd0:    w = uw(MUL_NONE, SRC_X,  GN_AA, ACC_NONE, DST_NONE, 1'b0, JMP_WAIT_IN, 1'b0);
            5'd1:    w = uw(MUL_LO,   SRC_AE, GN_AA, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd2:    w = uw(MUL_HI,   SRC_AE, GN_AA, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd3:    w = uw(MUL_LO,   SRC_RE, GN_AR, ACC_SUB,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd4:    w = uw(MUL_HI,   SRC_RE, GN_AR, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd5:    w = uw(MUL_LO,   SRC_LT, GN_AT, ACC_ADD,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd6:    w = uw(MUL_HI,   SRC_LT, GN_AT, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd7:    w = uw(MUL_LO,   SRC_X,  GN_AM, ACC_SUB,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd8:    w = uw(MUL_HI,   SRC_X,  GN_AM, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd9:    w = uw(MUL_LO,   SRC_AE, GN_RA, ACC_ADD,  DST_NA,   1'b1, JMP_NONE, 1'b0);
            5'd10:   w = uw(MUL_HI,   SRC_AE, GN_RA, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd11:   w = uw(MUL_LO,   SRC_RE, GN_RR, ACC_SUB,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd12:   w = uw(MUL_HI,   SRC_RE, GN_RR, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd13:   w = uw(MUL_LO,   SRC_LT, GN_RT, ACC_ADD,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd14:   w = uw(MUL_HI,   SRC_LT, GN_RT, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd15:   w = uw(MUL_LO,   SRC_X,  GN_RM, ACC_SUB,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd16:   w = uw(MUL_HI,   SRC_X,  GN_RM, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd17:   w = uw(MUL_LO,   SRC_NA, GN_TA, ACC_ADD,  DST_NR,   1'b0, JMP_NONE, 1'b0);
            5'd18:   w = uw(MUL_HI,   SRC_NA, GN_TA, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd19:   w = uw(MUL_LO,   SRC_NR, GN_TR, ACC_ADD,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd20:   w = uw(MUL_HI,   SRC_NR, GN_TR, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd21:   w = uw(MUL_LO,   SRC_EI, GN_TI, ACC_ADD,  DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd22:   w = uw(MUL_HI,   SRC_EI, GN_TI, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b0);
            5'd23:   w = uw(MUL_NONE, SRC_EI, GN_TI, ACC_ADD,  DST_T,    1'b0, JMP_WAIT_OUT, 1'b1);
            default: w = uw(MUL_NONE, SRC_X,  GN_AA, ACC_NONE, DST_NONE, 1'b0, JMP_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/obsfb_seq.sv
// obsfb_seq: step counter, control store lookup and wait conditions
`default_nettype none
module obsfb_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    output obsfb_pkg::ctl_t      ctl
);

    logic [obsfb_pkg::PC_W-1:0] pc_reg;
    logic [obsfb_pkg::PC_W-1:0] pc_next;
    obsfb_pkg::ucw_t            word;
    logic                       hold;

    always_comb
    begin
        word = obsfb_pkg::ucode(pc_reg);
        hold = ((word.jmp == obsfb_pkg::JMP_WAIT_IN) && !in_valid) ||
               ((word.jmp == obsfb_pkg::JMP_WAIT_OUT) && out_valid && out_stall);
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (word.last)
        begin
            pc_next = '0;
        end
        else
        begin
            pc_next = pc_reg + obsfb_pkg::PC_W'(1);
        end
        in_stall  = (word.jmp != obsfb_pkg::JMP_WAIT_IN);
        ctl.word  = word;
        ctl.exec  = !hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/obsfb_dp.sv
// obsfb_dp: state registers, shared gain multiplier, accumulator and output register
`default_nettype none
module obsfb_dp #(
    parameter int STATE_WIDTH = obsfb_pkg::STATE_WIDTH_DEF,
    parameter int FRAC_BITS   = obsfb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire obsfb_pkg::ctl_t                     ctl,
    input  wire logic signed [obsfb_pkg::ANGLE_W-1:0] angle_sample,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [obsfb_pkg::CMD_W-1:0]       motor_command
);

    localparam int GF   = obsfb_pkg::GAIN_FRAC;
    localparam int SHL  = (FRAC_BITS >= obsfb_pkg::ANGLE_FRAC) ?
                          (FRAC_BITS - obsfb_pkg::ANGLE_FRAC) : 0;
    localparam int SHR  = (FRAC_BITS < obsfb_pkg::ANGLE_FRAC) ?
                          (obsfb_pkg::ANGLE_FRAC - FRAC_BITS) : 0;
    localparam int XW   = obsfb_pkg::ANGLE_W + SHL;
    localparam int OPW  = (STATE_WIDTH > XW) ? STATE_WIDTH : XW;
    localparam int HI_W = OPW - GF + 1;
    localparam int MA_W = (HI_W > GF + 1) ? HI_W : (GF + 1);
    localparam int PW   = MA_W + obsfb_pkg::GAIN_W + 1;
    localparam int ACC_W = OPW + 9;
    localparam int CW   = obsfb_pkg::CMD_W;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (GF - 1);

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [ACC_W-1:0] v);
        logic signed [STATE_WIDTH-1:0] r;
        if ((&v[ACC_W-1:STATE_WIDTH-1]) || !(|v[ACC_W-1:STATE_WIDTH-1]))
        begin
            r = v[STATE_WIDTH-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_cmd(input logic signed [ACC_W-1:0] v);
        logic signed [CW-1:0] r;
        if ((&v[ACC_W-1:CW-1]) || !(|v[ACC_W-1:CW-1]))
        begin
            r = v[CW-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [STATE_WIDTH-1:0] ae_reg, re_reg, ei_reg, lt_reg, na_reg, nr_reg;
    logic signed [OPW-1:0]         x_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [PW-1:0]          prod_reg, part_reg;
    logic signed [CW-1:0]          cmd_reg;
    logic                          out_valid_reg;

    logic signed [OPW-1:0]         ext, x_new, opnd;
    logic signed [HI_W-1:0]        hi;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [obsfb_pkg::GAIN_W:0] mul_g;
    logic signed [PW-1:0]          product;
    logic signed [PW:0]            term_full;
    logic signed [ACC_W-1:0]       term, sum, ei_diff;
    logic signed [STATE_WIDTH-1:0] sum_sat;
    logic signed [CW-1:0]          cmd_new;

    always_comb
    begin
        ext   = OPW'(angle_sample);
        x_new = (FRAC_BITS >= obsfb_pkg::ANGLE_FRAC) ? (ext <<< SHL) : (ext >>> SHR);
        case (ctl.word.src)
            obsfb_pkg::SRC_AE: opnd = OPW'(ae_reg);
            obsfb_pkg::SRC_RE: opnd = OPW'(re_reg);
            obsfb_pkg::SRC_LT: opnd = OPW'(lt_reg);
            obsfb_pkg::SRC_X:  opnd = x_reg;
            obsfb_pkg::SRC_NA: opnd = OPW'(na_reg);
            obsfb_pkg::SRC_NR: opnd = OPW'(nr_reg);
            obsfb_pkg::SRC_EI: opnd = OPW'(ei_reg);
            default:           opnd = '0;
        endcase
        hi = HI_W'(opnd >>> GF);
        if (ctl.word.mul == obsfb_pkg::MUL_HI)
        begin
            mul_a = MA_W'(hi);
        end
        else
        begin
            mul_a = MA_W'($signed({1'b0, opnd[GF-1:0]}));
        end
        mul_g     = $signed({1'b0, obsfb_pkg::gain_value(ctl.word.gain)});
        product   = PW'(mul_a * mul_g);
        term_full = $signed({prod_reg[PW-1], prod_reg}) + $signed({part_reg[PW-1], part_reg});
        term      = term_full[ACC_W-1:0];
        if (ctl.word.acc == obsfb_pkg::ACC_SUB)
        begin
            sum = acc_reg - term;
        end
        else
        begin
            sum = acc_reg + term;
        end
        sum_sat = sat_state(sum);
        ei_diff = ACC_W'(ei_reg) - ACC_W'(x_reg);
        cmd_new = sat_cmd(ACC_W'(sum_sat) >>> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ae_reg        <= '0;
            re_reg        <= '0;
            ei_reg        <= '0;
            lt_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec && ctl.word.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.exec)
            begin
                if (ctl.word.acc != obsfb_pkg::ACC_NONE)
                begin
                    acc_reg <= (ctl.word.dst != obsfb_pkg::DST_NONE) ? '0 : sum;
                end
                if (ctl.word.integ)
                begin
                    ei_reg <= sat_state(ei_diff);
                end
                if (ctl.word.dst == obsfb_pkg::DST_T)
                begin
                    lt_reg <= sum_sat;
                    ae_reg <= na_reg;
                    re_reg <= nr_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            if (ctl.word.jmp == obsfb_pkg::JMP_WAIT_IN)
            begin
                x_reg <= x_new;
            end
            if (ctl.word.mul == obsfb_pkg::MUL_LO)
            begin
                prod_reg <= product;
            end
            else if (ctl.word.mul == obsfb_pkg::MUL_HI)
            begin
                prod_reg <= product;
                part_reg <= (prod_reg + RND) >>> GF;
            end
            if (ctl.word.dst == obsfb_pkg::DST_NA)
            begin
                na_reg <= sum_sat;
            end
            if (ctl.word.dst == obsfb_pkg::DST_NR)
            begin
                nr_reg <= sum_sat;
            end
            if (ctl.word.last)
            begin
                cmd_reg <= cmd_new;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_command = cmd_reg;

endmodule
`default_nettype wire

// File: rtl/observer_state_feedback_integral_top.sv
// observer_state_feedback_integral_top: balance controller with observer, state feedback and integral
// Takes one signed Q2.13 pitch angle per request and returns one saturated Q16.16 motor command
// (half the torque, shared by both motors). A new angle is not accepted while the previous one
// is still in work: a microcoded sequencer drives one shared 25x31 gain multiplier through eleven
// products, two multiplier passes each, with the accumulation of one product overlapped with the
// next, plus one step that takes the angle and a final step that adds the last product. The
// next angle is accepted in the cycle after the previous command is loaded into the output
// register, so a waiting command does not block a new request; only the final step waits for the
// output to drain.
`default_nettype none
module observer_state_feedback_integral_top #(
    parameter int STATE_WIDTH = obsfb_pkg::STATE_WIDTH_DEF,
    parameter int FRAC_BITS   = obsfb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [obsfb_pkg::ANGLE_W-1:0] angle_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [obsfb_pkg::CMD_W-1:0]        motor_command
);

    obsfb_pkg::ctl_t ctl;

    obsfb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    obsfb_dp #(
        .STATE_WIDTH (STATE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .angle_sample  (angle_sample),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .motor_command (motor_command)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a request");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared right after acceptance");

    a_last_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && ctl.word.last && ctl.word.dst == obsfb_pkg::DST_T) |=> out_valid)
        else $error("final step did not load the output register");

    a_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.word.jmp == obsfb_pkg::JMP_WAIT_OUT && out_valid && out_stall) |-> !ctl.exec)
        else $error("final step ran over a held result");
`endif

endmodule
`default_nettype wire

// File: verif/obsfb_command_checker.sv
// obsfb_command_checker: predicts the motor command per angle request and compares the results
module obsfb_command_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [obsfb_pkg::ANGLE_W-1:0]   angle_sample,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [obsfb_pkg::CMD_W-1:0]     motor_command,
    output int                                     mismatches,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATE_BITS = obsfb_pkg::STATE_WIDTH_DEF;
    localparam int FRAC       = obsfb_pkg::FRAC_BITS_DEF;
    localparam int CMD_BITS   = obsfb_pkg::CMD_W;

    localparam longint K_ANG_ANG  = 13015764;
    localparam longint K_ANG_RATE = 46708;
    localparam longint K_ANG_TRQ  = 523785;
    localparam longint K_ANG_MEAS = 18139526;
    localparam longint K_RATE_ANG  = 763690484;
    localparam longint K_RATE_RATE = 10643466;
    localparam longint K_RATE_TRQ  = 199185819;
    localparam longint K_RATE_MEAS = 787014169;
    localparam longint K_TRQ_ANG  = 7857945;
    localparam longint K_TRQ_RATE = 460870;
    localparam longint K_TRQ_INT  = 251188;

    longint angle_est;
    longint rate_est;
    longint integ_sum;
    longint trq_last;

    logic [CMD_BITS-1:0] expected_commands[$];
    logic [CMD_BITS-1:0] want;
    int                  errs;

    // value times gain, rounded half up to the state fraction
    function automatic longint apply_gain(input longint v, input longint g);
        longint lo;
        longint hi;
        longint part;
        lo   = v & ((64'sd1 <<< obsfb_pkg::GAIN_FRAC) - 64'sd1);
        hi   = v >>> obsfb_pkg::GAIN_FRAC;
        part = (lo * g + (64'sd1 <<< (obsfb_pkg::GAIN_FRAC - 1))) >>> obsfb_pkg::GAIN_FRAC;
        return hi * g + part;
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic [CMD_BITS-1:0] next_motor_command(
        input logic signed [obsfb_pkg::ANGLE_W-1:0] angle
    );
        longint meas;
        longint new_ang;
        longint new_rate;
        longint trq;
        if (FRAC >= obsfb_pkg::ANGLE_FRAC)
        begin
            meas = longint'(angle) <<< (FRAC - obsfb_pkg::ANGLE_FRAC);
        end
        else
        begin
            meas = longint'(angle) >>> (obsfb_pkg::ANGLE_FRAC - FRAC);
        end
        new_ang  = -apply_gain(angle_est, K_ANG_ANG) + apply_gain(rate_est, K_ANG_RATE)
                   - apply_gain(trq_last, K_ANG_TRQ) + apply_gain(meas, K_ANG_MEAS);
        new_rate = -apply_gain(angle_est, K_RATE_ANG) + apply_gain(rate_est, K_RATE_RATE)
                   - apply_gain(trq_last, K_RATE_TRQ) + apply_gain(meas, K_RATE_MEAS);
        new_ang  = clamp_bits(new_ang, STATE_BITS);
        new_rate = clamp_bits(new_rate, STATE_BITS);
        integ_sum = clamp_bits(integ_sum - meas, STATE_BITS);
        trq = apply_gain(new_ang, K_TRQ_ANG) + apply_gain(new_rate, K_TRQ_RATE)
              + apply_gain(integ_sum, K_TRQ_INT);
        trq = clamp_bits(trq, STATE_BITS);
        angle_est = new_ang;
        rate_est  = new_rate;
        trq_last  = trq;
        return CMD_BITS'(clamp_bits(trq >>> 1, CMD_BITS));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_est = 0;
            rate_est  = 0;
            integ_sum = 0;
            trq_last  = 0;
            expected_commands.delete();
            errs = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_commands.size() == 0)
                begin
                    if (errs < 10)
                    begin
                        $display("unexpected command %h at %0t", motor_command, $realtime);
                    end
                    errs++;
                end
                else
                begin
                    want = expected_commands.pop_front();
                    if (want !== motor_command)
                    begin
                        if (errs < 10)
                        begin
                            $display("command mismatch at %0t: expected %h (%0d) actual %h (%0d)",
                                     $realtime, want, $signed(want), motor_command,
                                     motor_command);
                        end
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_commands.push_back(next_motor_command(angle_sample));
            end
            mismatches <= errs;
            pending    <= expected_commands.size();
        end
    end

endmodule

// File: verif/tb_observer_state_feedback_integral_top.sv
// tb_observer_state_feedback_integral_top: clock, reset, angle stimulus, output stalls and verdict
module tb_observer_state_feedback_integral_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REQUESTS = 1250;

    typedef enum int {
        SEG_NOISE,
        SEG_HOLD,
        SEG_RAMP,
        SEG_JITTER
    } seg_kind_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [obsfb_pkg::ANGLE_W-1:0]   angle_sample;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [obsfb_pkg::CMD_W-1:0]     motor_command;
    int                                     mismatches;
    int                                     pending;
    int                                     sent;

    observer_state_feedback_integral_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .angle_sample  (angle_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_command (motor_command)
    );

    obsfb_command_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .angle_sample  (angle_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_command (motor_command),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #15ms;
        $display("Some tests failed");
        $finish;
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_angle(input logic [obsfb_pkg::ANGLE_W-1:0] v, input bit calm);
        int gap;
        in_valid     <= 1'b1;
        angle_sample <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [obsfb_pkg::ANGLE_W-1:0] directed[$];
        seg_kind_t                     kind;
        int                            seg_len;
        int                            level;
        int                            step;
        bit                            calm;
        logic [obsfb_pkg::ANGLE_W-1:0] v;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        angle_sample = '0;
        sent         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h4000,
                     16'hc000, 16'h0000, 16'h5555, 16'haaaa};
        for (int i = 0; i < 7; i++)
        begin
            directed.push_back(16'h7fff);
        end
        for (int i = 0; i < 7; i++)
        begin
            directed.push_back(16'h8000);
        end
        foreach (directed[i])
        begin
            offer_angle(directed[i], i[0]);
        end

        while (sent < NUM_REQUESTS)
        begin
            kind    = seg_kind_t'($urandom_range(0, 3));
            seg_len = $urandom_range(5, 60);
            calm    = ($urandom_range(0, 4) == 0);
            level   = $signed(16'($urandom));
            step    = $urandom_range(0, 512) - 256;
            if (kind == SEG_HOLD && $urandom_range(0, 2) == 0)
            begin
                level = $urandom_range(0, 1) ? 32767 : -32768;
            end
            for (int i = 0; i < seg_len; i++)
            begin
                case (kind)
                    SEG_NOISE:  v = 16'($urandom);
                    SEG_HOLD:   v = 16'(level);
                    SEG_RAMP:   v = 16'(level + i * step);
                    SEG_JITTER: v = 16'(level + $urandom_range(0, 64) - 32);
                    default:    v = '0;
                endcase
                offer_angle(v, calm);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        int stall_len;
        int run_len;
        int elapsed;
        bit held;
        out_stall = 1'b0;
        elapsed   = 0;
        held      = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall_len = pick_gap();
            run_len   = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 8);
            // long hold-off so the block backs up into its input
            if (!held && elapsed > 1500)
            begin
                held      = 1'b1;
                stall_len = 400;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (run_len) @(posedge clk);
            elapsed += stall_len + run_len;
        end
    end

endmodule
